@@ rtl/pptc_pkg.sv @@
// ----------------------------------------------------------------------------
// pptc_pkg
// Shared constants for the pad pedestal / threshold calculator: field widths,
// register indexes and reset values, trace-correction and rounding constants.
// ----------------------------------------------------------------------------
package pptc_pkg;

	// Default fraction bits of all ADC values (Q.4)
	localparam int FRAC_BITS_DEF = 4;

	// Port field widths
	localparam int ADC_IN_W   = 16;
	localparam int TRACE_W    = 12;
	localparam int ADC_OUT_W  = 14;
	localparam int THR_PHYS_W = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA_GAIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEDESTAL_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_BAD         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISY_LIMIT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOISY_SIGMA_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAD_LIMIT        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_QUARTER    = 3'd7;

	// Register reset values
	localparam logic [15:0]        RST_SIGMA_GAIN       = 16'd768;
	localparam logic [13:0]        RST_MIN_THRESHOLD    = 14'd32;
	localparam logic [13:0]        RST_PEDESTAL_OFFSET  = 14'd0;
	localparam logic               RST_MASK_BAD         = 1'b0;
	localparam logic signed [15:0] RST_NOISY_LIMIT      = 16'sd48;
	localparam logic [15:0]        RST_NOISY_SIGMA_GAIN = 16'd1024;
	localparam logic signed [15:0] RST_BAD_LIMIT        = 16'sd160;
	localparam logic               RST_ROUND_QUARTER    = 1'b1;

	// Trace correction: C0 + C1 * trace, both scaled by 2^16 (trace is Q.4)
	localparam int CORR_W   = 24;
	localparam int CORR_C0  = 55548;
	localparam int CORR_C1  = 2065;
	localparam int CORR_FRAC = 20;

	// Rounding constant of the Q8.8 gain products
	localparam int GAIN_FRAC = 8;
	localparam int GAIN_RND  = 128;

endpackage

@@ rtl/pptc_if.sv @@
// ----------------------------------------------------------------------------
// pptc_in_if / pptc_out_if
// Valid/ready channels carrying one pad request in and one result out.
// ----------------------------------------------------------------------------
interface pptc_in_if import pptc_pkg::*; ;
	logic                       valid;
	logic                       ready;
	logic signed [ADC_IN_W-1:0] pedestal_in;
	logic signed [ADC_IN_W-1:0] noise_in;
	logic [TRACE_W-1:0]         trace_len;

	modport source (output valid, output pedestal_in, output noise_in, output trace_len,
		input ready);
	modport sink (input valid, input pedestal_in, input noise_in, input trace_len,
		output ready);
endinterface

interface pptc_out_if import pptc_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [ADC_OUT_W-1:0]  pedestal_out;
	logic [ADC_OUT_W-1:0]  threshold_out;
	logic [ADC_OUT_W-1:0]  pedestal_phys;
	logic [THR_PHYS_W-1:0] threshold_phys;
	logic                  value_bad;
	logic                  offset_too_large;

	modport source (output valid, output pedestal_out, output threshold_out,
		output pedestal_phys, output threshold_phys, output value_bad,
		output offset_too_large, input ready);
	modport sink (input valid, input pedestal_out, input threshold_out,
		input pedestal_phys, input threshold_phys, input value_bad,
		input offset_too_large, output ready);
endinterface

@@ rtl/pad_pedestal_threshold_calc.sv @@
// ----------------------------------------------------------------------------
// pad_pedestal_threshold_calc
// Per-pad zero-suppression pedestal/threshold calculator, five-stage pipeline.
// ----------------------------------------------------------------------------
// Pipeline: a request is loaded into the first of five register stages at the
//   edge that accepts it, and the last of those stages drives out_ch.
// Throughput: one pad per cycle; each stage holds while the stage after it is
//   full and stalled, so a blocked output backs up stage by stage.
// Stage work: offset/abs/trace term, limit compares and masking, two gain
//   multipliers, clamps and selection, optional quarter rounding into output register.
// Reset (arst_n low): all stage valid bits clear, config registers take their defaults.
module pad_pedestal_threshold_calc import pptc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	pptc_in_if.sink              in_ch,
	pptc_out_if.source           out_ch
);

	// Value widths and limits derived from the fraction bits
	localparam int NW = 10 + FRAC_BITS;          // holds 1023 ADC units
	localparam int VW = NW + GAIN_FRAC;          // gain product after rounding
	localparam int PW = NW + 16;                 // raw gain product
	localparam int QW = (NW > 17) ? NW : 17;     // quarter rounding work width
	localparam int QSTEP = 1 << (FRAC_BITS - 2);
	localparam int QHALF = QSTEP >> 1;
	localparam int CORR_SHIFT = CORR_FRAC - FRAC_BITS;

	localparam logic [NW-1:0]        ADC_MAX   = NW'(1023 << FRAC_BITS);
	localparam logic signed [16:0]   PED_MAX   = 17'(150 << FRAC_BITS);
	localparam logic [15:0]          NOISE_MAX = 16'(50 << FRAC_BITS);
	localparam logic [QW-1:0]        Q_CLR     = ~QW'(QSTEP - 1);
	localparam logic [QW-1:0]        Q_WRAP    = QW'((1 << NW) - 1);
	localparam logic [THR_PHYS_W-1:0] PHYS_SAT = 16'hFFFF;
	localparam logic [THR_PHYS_W-1:0] PHYS_SAT_Q = 16'hFFFF & ~16'(QSTEP - 1);

	// Configuration registers
	logic [15:0]        sigma_gain_q;
	logic [13:0]        min_threshold_q;
	logic [13:0]        pedestal_offset_q;
	logic               mask_bad_q;
	logic signed [15:0] noisy_limit_q;
	logic [15:0]        noisy_sigma_gain_q;
	logic signed [15:0] bad_limit_q;
	logic               round_quarter_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_gain_q       <= RST_SIGMA_GAIN;
			min_threshold_q    <= RST_MIN_THRESHOLD;
			pedestal_offset_q  <= RST_PEDESTAL_OFFSET;
			mask_bad_q         <= RST_MASK_BAD;
			noisy_limit_q      <= RST_NOISY_LIMIT;
			noisy_sigma_gain_q <= RST_NOISY_SIGMA_GAIN;
			bad_limit_q        <= RST_BAD_LIMIT;
			round_quarter_q    <= RST_ROUND_QUARTER;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SIGMA_GAIN:       sigma_gain_q       <= cfg_wdata;
				REG_MIN_THRESHOLD:    min_threshold_q    <= cfg_wdata[13:0];
				REG_PEDESTAL_OFFSET:  pedestal_offset_q  <= cfg_wdata[13:0];
				REG_MASK_BAD:         mask_bad_q         <= cfg_wdata[0];
				REG_NOISY_LIMIT:      noisy_limit_q      <= $signed(cfg_wdata);
				REG_NOISY_SIGMA_GAIN: noisy_sigma_gain_q <= cfg_wdata;
				REG_BAD_LIMIT:        bad_limit_q        <= $signed(cfg_wdata);
				REG_ROUND_QUARTER:    round_quarter_q    <= cfg_wdata[0];
			endcase
		end
	end

	// Stage valids and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !vld_s5 || out_ch.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_ch.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- Stage 1: offset, absolute noise, trace term ----------------
	logic signed [16:0] ped_x, offs_x, ped_c;
	logic               off_big_c;
	logic [15:0]        noise_abs_c;
	logic [CORR_W-1:0]  corr_c;

	assign ped_x     = {in_ch.pedestal_in[15], in_ch.pedestal_in};
	assign offs_x    = $signed({3'b000, pedestal_offset_q});
	assign off_big_c = (in_ch.pedestal_in > 16'sd0) && (offs_x > ped_x);
	assign ped_c     = off_big_c ? ped_x : ped_x - offs_x;
	assign noise_abs_c = in_ch.noise_in[15] ? (~in_ch.noise_in + 16'd1) : in_ch.noise_in;
	assign corr_c    = CORR_W'(CORR_C0 * 16) + CORR_W'(in_ch.trace_len) * CORR_W'(CORR_C1);

	logic signed [16:0] ped_s1;
	logic [15:0]        noise_s1;
	logic [CORR_W-1:0]  corr_s1;
	logic               off_big_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ped_s1     <= ped_c;
			noise_s1   <= noise_abs_c;
			corr_s1    <= corr_c >> CORR_SHIFT;
			off_big_s1 <= off_big_c;
		end
	end

	// ---------------- Stage 2: limit compares, range check, masking ----------------
	logic signed [17:0] noise_sx, diff_noisy, diff_bad;
	logic signed [24:0] corr_sx;
	logic               noisy_c, badpad_c, bad_c;
	logic [NW-1:0]      mask_val, ped_v, noise_v;

	assign noise_sx   = $signed({2'b00, noise_s1});
	assign diff_noisy = noise_sx - {{2{noisy_limit_q[15]}}, noisy_limit_q};
	assign diff_bad   = noise_sx - {{2{bad_limit_q[15]}}, bad_limit_q};
	assign corr_sx    = $signed({1'b0, corr_s1});
	assign noisy_c    = $signed({{7{diff_noisy[17]}}, diff_noisy}) > corr_sx;
	assign badpad_c   = $signed({{7{diff_bad[17]}}, diff_bad}) > corr_sx;
	assign bad_c      = (ped_s1 <= 17'sd0) || (ped_s1 > PED_MAX) ||
		(noise_s1 == 16'd0) || (noise_s1 > NOISE_MAX);
	assign mask_val   = mask_bad_q ? ADC_MAX : '0;
	assign ped_v      = bad_c ? mask_val : NW'(ped_s1);
	assign noise_v    = bad_c ? mask_val : NW'(noise_s1);

	logic [NW-1:0] ped_s2, noise_s2;
	logic          noisy_s2, badpad_s2, bad_s2, off_big_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			ped_s2     <= ped_v;
			noise_s2   <= noise_v;
			noisy_s2   <= noisy_c;
			badpad_s2  <= badpad_c;
			bad_s2     <= bad_c;
			off_big_s2 <= off_big_s1;
		end
	end

	// ---------------- Stage 3: gain products ----------------
	logic [NW-1:0] ped_s3;
	logic          noise_nz_s3, noisy_s3, badpad_s3, bad_s3, off_big_s3;
	logic [PW-1:0] prod_n_s3, prod_y_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			ped_s3      <= ped_s2;
			noise_nz_s3 <= (noise_s2 != '0);
			prod_n_s3   <= PW'(sigma_gain_q) * PW'(noise_s2);
			prod_y_s3   <= PW'(noisy_sigma_gain_q) * PW'(noise_s2);
			noisy_s3    <= noisy_s2;
			badpad_s3   <= badpad_s2;
			bad_s3      <= bad_s2;
			off_big_s3  <= off_big_s2;
		end
	end

	// ---------------- Stage 4: round products, clamp, select physics pair ----------------
	logic [PW-1:0]         rnd_n, rnd_y;
	logic [VW-1:0]         g_n, g_y, minth_x, thr_lo, thr_y;
	logic [NW-1:0]         thr_c, pedp_c;
	logic [VW-1:0]         thrp_w;
	logic [THR_PHYS_W-1:0] thrp_c;

	assign rnd_n   = prod_n_s3 + PW'(GAIN_RND);
	assign rnd_y   = prod_y_s3 + PW'(GAIN_RND);
	assign g_n     = rnd_n[PW-1:GAIN_FRAC];
	assign g_y     = rnd_y[PW-1:GAIN_FRAC];
	assign minth_x = VW'(min_threshold_q);
	assign thr_lo  = !noise_nz_s3 ? '0 : ((g_n < minth_x) ? minth_x : g_n);
	assign thr_c   = (thr_lo > VW'(ADC_MAX)) ? ADC_MAX : NW'(thr_lo);
	assign thr_y   = (g_y < minth_x) ? minth_x : g_y;

	// Bad pads override, then saturate the physics threshold
	always_comb begin
		pedp_c = ped_s3;
		thrp_w = noisy_s3 ? thr_y : VW'(thr_c);
		if (badpad_s3) begin
			pedp_c = ADC_MAX;
			thrp_w = VW'(ADC_MAX);
		end
		thrp_c = (thrp_w > VW'(PHYS_SAT)) ? PHYS_SAT : THR_PHYS_W'(thrp_w);
	end

	logic [NW-1:0]         ped_s4, thr_s4, pedp_s4;
	logic [THR_PHYS_W-1:0] thrp_s4;
	logic                  bad_s4, off_big_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			ped_s4     <= ped_s3;
			thr_s4     <= thr_c;
			pedp_s4    <= pedp_c;
			thrp_s4    <= thrp_c;
			bad_s4     <= bad_s3;
			off_big_s4 <= off_big_s3;
		end
	end

	// ---------------- Stage 5: quarter rounding into output register ----------------
	// Round half up to a quarter ADC step, then wrap at 1024 ADC units
	function automatic logic [QW-1:0] quarter(input logic [QW-1:0] x);
		logic [QW-1:0] s;
		s = x + QW'(QHALF);
		return s & Q_CLR & Q_WRAP;
	endfunction

	logic [QW-1:0]         ped_q, thr_q, pedp_q, thrp_q;
	logic [QW-1:0]         ped_r, thr_r, pedp_r;
	logic [THR_PHYS_W-1:0] thrp_r;

	assign ped_q  = quarter(QW'(ped_s4));
	assign thr_q  = quarter(QW'(thr_s4));
	assign pedp_q = quarter(QW'(pedp_s4));
	assign thrp_q = quarter(QW'(thrp_s4));
	assign ped_r  = round_quarter_q ? ped_q : QW'(ped_s4);
	assign thr_r  = round_quarter_q ? thr_q : QW'(thr_s4);
	assign pedp_r = round_quarter_q ? pedp_q : QW'(pedp_s4);
	assign thrp_r = !round_quarter_q ? thrp_s4 :
		((thrp_q > QW'(PHYS_SAT)) ? PHYS_SAT_Q : thrp_q[THR_PHYS_W-1:0]);

	logic [ADC_OUT_W-1:0]  ped_s5, thr_s5, pedp_s5;
	logic [THR_PHYS_W-1:0] thrp_s5;
	logic                  bad_s5, off_big_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			ped_s5     <= ped_r[ADC_OUT_W-1:0];
			thr_s5     <= thr_r[ADC_OUT_W-1:0];
			pedp_s5    <= pedp_r[ADC_OUT_W-1:0];
			thrp_s5    <= thrp_r;
			bad_s5     <= bad_s4;
			off_big_s5 <= off_big_s4;
		end
	end

	// Drive result channel
	assign out_ch.valid            = vld_s5;
	assign out_ch.pedestal_out     = ped_s5;
	assign out_ch.threshold_out    = thr_s5;
	assign out_ch.pedestal_phys    = pedp_s5;
	assign out_ch.threshold_phys   = thrp_s5;
	assign out_ch.value_bad        = bad_s5;
	assign out_ch.offset_too_large = off_big_s5;

endmodule

@@ rtl/pptc_chk.sv @@
// ----------------------------------------------------------------------------
// pptc_chk
// Port-level checks on the calculator's channels, bound to the top level.
// ----------------------------------------------------------------------------
module pptc_chk import pptc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [ADC_OUT_W-1:0]  pedestal_out,
	input logic [ADC_OUT_W-1:0]  threshold_out,
	input logic [ADC_OUT_W-1:0]  pedestal_phys,
	input logic [THR_PHYS_W-1:0] threshold_phys,
	input logic                  value_bad,
	input logic                  offset_too_large
);

	localparam int ADC_MAX_I = 1023 << FRAC_BITS;

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pedestal_out) &&
		$stable(threshold_out) && $stable(pedestal_phys) && $stable(threshold_phys) &&
		$stable(value_bad) && $stable(offset_too_large))
		else $error("result changed while stalled");

	// An empty output stage means the whole pipe can take a request
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result waiting");

	// Standard-run values never exceed 1023 ADC units
	a_std_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(threshold_out) <= ADC_MAX_I) && (int'(pedestal_out) <= ADC_MAX_I))
		else $error("standard-run value above range");

	// A zeroed bad pad has a zero threshold
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_bad && (pedestal_out == '0) |-> threshold_out == '0)
		else $error("zeroed bad pad with nonzero threshold");

	// Leave reset with no result
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present out of reset");

endmodule

bind pad_pedestal_threshold_calc pptc_chk #(.FRAC_BITS(FRAC_BITS)) u_pptc_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.pedestal_out     (out_ch.pedestal_out),
	.threshold_out    (out_ch.threshold_out),
	.pedestal_phys    (out_ch.pedestal_phys),
	.threshold_phys   (out_ch.threshold_phys),
	.value_bad        (out_ch.value_bad),
	.offset_too_large (out_ch.offset_too_large)
);
